/* design/lbe_pkg.sv */
`timescale 1ns / 1ps
// lbe_pkg: types and fixed constants shared by the LZW byte encoder modules.
// No dependencies.
package lbe_pkg;

  localparam int BYTE_W      = 8;   // raw symbol width
  localparam int CODE_OUT_W  = 12;  // code port width
  localparam int WIDTH_OUT_W = 4;   // code_width port width
  localparam int WIDTH_W     = 5;   // internal width register, holds up to 31
  localparam int TAG_W       = 4;   // stream epoch tag kept in each dictionary slot
  localparam int OUT_DEPTH   = 4;   // result queue entries
  localparam int OUT_PTR_W   = 2;
  localparam int OUT_CNT_W   = 3;

  localparam logic [TAG_W-1:0] EPOCH_FIRST = TAG_W'(1);
  localparam logic [TAG_W-1:0] EPOCH_LAST  = '1;
  localparam logic [TAG_W-1:0] EPOCH_CLEAR = '0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_CHECK,
    ST_FLUSH
  } lbe_state_t;

  typedef struct packed {
    logic [CODE_OUT_W-1:0]  code;
    logic [WIDTH_OUT_W-1:0] code_width;
    logic                   final_code;
  } lbe_result_t;

endpackage

/* design/lbe_dict_ram.sv */
`timescale 1ns / 1ps
// lbe_dict_ram: single write port, single read port dictionary memory,
// read data registered. No dependencies.
module lbe_dict_ram #(
  parameter int DEPTH  = 8192,
  parameter int DATA_W = 36
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/lbe_hash.sv */
`timescale 1ns / 1ps
// lbe_hash: two-stage key mod SLOTS reduction by reciprocal multiply
// and a single correcting subtract. Depends on lbe_pkg.
module lbe_hash import lbe_pkg::*; #(
  parameter int KEY_W = 20,
  parameter int SLOTS = 8192
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [KEY_W-1:0]         key,
  output logic                     out_valid,
  output logic [$clog2(SLOTS)-1:0] slot
);

  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int RECIP    = (1 << KEY_W) / SLOTS;
  localparam int RECIP_W  = KEY_W - SLOT_W + 1;
  localparam int PROD_W   = KEY_W + RECIP_W;

  logic              v1;
  logic [KEY_W-1:0]  key1;
  logic [PROD_W-1:0] prod1;

  logic [RECIP_W-1:0] quot;
  logic [KEY_W:0]     quot_n;
  logic [KEY_W:0]     rem_wide;
  logic [SLOT_W:0]    rem0;
  logic [SLOT_W:0]    rem1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    key1  <= key;
    prod1 <= PROD_W'(key) * PROD_W'(RECIP_W'(RECIP));
  end

  // quotient estimate is exact or one low, so the remainder is below 2*SLOTS
  always_comb begin
    quot     = prod1[PROD_W-1:KEY_W];
    quot_n   = (KEY_W+1)'(quot) * (KEY_W+1)'(SLOTS);
    rem_wide = (KEY_W+1)'(key1) - quot_n;
    rem0     = rem_wide[SLOT_W:0];
    rem1     = (rem0 >= (SLOT_W+1)'(SLOTS)) ? rem0 - (SLOT_W+1)'(SLOTS) : rem0;
  end

  always_ff @(posedge clk) begin
    slot <= rem1[SLOT_W-1:0];
  end

endmodule

/* design/lbe_out_fifo.sv */
`timescale 1ns / 1ps
// lbe_out_fifo: small result queue driving the code channel.
// Depends on lbe_pkg.
module lbe_out_fifo import lbe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  lbe_result_t          push_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output lbe_result_t          out_data,
  output logic [OUT_CNT_W-1:0] count
);

  lbe_result_t            entries [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   head;
  logic [OUT_PTR_W-1:0]   tail;
  logic                   pop;
  logic [OUT_CNT_W-1:0]   count_next;

  assign out_valid = (count != '0);
  assign out_data  = entries[head];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + OUT_CNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - OUT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        tail <= tail + OUT_PTR_W'(1);
      end
      if (pop) begin
        head <= head + OUT_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_data;
    end
  end

endmodule

/* design/lzw_byte_encoder.sv */
`timescale 1ns / 1ps
// lzw_byte_encoder: variable-width LZW encoder with a hashed dictionary
// in one synchronous RAM. Depends on lbe_pkg, lbe_dict_ram, lbe_hash, lbe_out_fifo.
//
//   channel  signals                                   handshake
//   input    data_byte, end_of_stream                  data_valid / data_stall
//   output   code, code_width, final_code              code_valid / code_stall
//
// The first byte of a stream only loads the prefix. A later byte is hashed
// and then probes the dictionary, with further linear probes (one RAM read
// per cycle) until a hit, a free slot or a full sweep. A byte flagged end_of_stream adds a flush.
// After reset, and after every 15th stream when the epoch tag wraps, a
// clearing pass over all HASH_SLOTS slots runs with data_stall high.
// Results queue in four entries; input is taken only while two of them are free.
module lzw_byte_encoder import lbe_pkg::*; #(
  parameter int ALPHABET_ENTRIES = 256,
  parameter int START_WIDTH      = 9,
  parameter int MAX_CODE_BITS    = 12,
  parameter int HASH_SLOTS       = 8192
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   data_valid,
  output logic                   data_stall,
  input  logic [BYTE_W-1:0]      data_byte,
  input  logic                   end_of_stream,
  output logic                   code_valid,
  input  logic                   code_stall,
  output logic [CODE_OUT_W-1:0]  code,
  output logic [WIDTH_OUT_W-1:0] code_width,
  output logic                   final_code
);

  localparam int SLOT_W  = $clog2(HASH_SLOTS);
  localparam int PROBE_W = $clog2(HASH_SLOTS + 1);
  localparam int KEY_W   = MAX_CODE_BITS + BYTE_W;
  localparam int NFC_W   = MAX_CODE_BITS + 1;
  localparam int WP_W    = $clog2(ALPHABET_ENTRIES) + 1 + MAX_CODE_BITS;
  localparam int ENTRY_W = TAG_W + KEY_W + MAX_CODE_BITS;

  localparam logic [BYTE_W:0]   ALPHA_LIM  = (BYTE_W+1)'(ALPHABET_ENTRIES);
  localparam logic [BYTE_W-1:0] BYTE_TOP   = BYTE_W'(ALPHABET_ENTRIES - 1);
  localparam logic [NFC_W-1:0]  NFC_RESET  = NFC_W'(ALPHABET_ENTRIES);
  localparam logic [WP_W-1:0]   WP_RESET   = WP_W'(2 * ALPHABET_ENTRIES);
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(START_WIDTH);
  localparam logic [WIDTH_W-1:0] WIDTH_MAX   = WIDTH_W'(MAX_CODE_BITS);
  localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(HASH_SLOTS - 1);
  localparam logic [PROBE_W-1:0] PROBE_ALL = PROBE_W'(HASH_SLOTS);

  lbe_state_t state;
  lbe_state_t state_next;

  logic [MAX_CODE_BITS-1:0] prefix_code;
  logic                     prefix_valid;
  logic [NFC_W-1:0]         next_free_code;
  logic [WIDTH_W-1:0]       current_width;
  logic [WP_W-1:0]          widen_point;
  logic [TAG_W-1:0]         epoch;
  logic [BYTE_W-1:0]        cur_byte;
  logic                     cur_eos;
  logic [KEY_W-1:0]         cur_key;
  logic [SLOT_W-1:0]        pos;
  logic [SLOT_W-1:0]        pos_next;
  logic [PROBE_W-1:0]       probes;
  logic [SLOT_W-1:0]        clr_idx;

  logic [BYTE_W-1:0]        byte_sat;
  logic [KEY_W-1:0]         key_in;
  logic                     accept;
  logic                     hash_go;
  logic                     hash_valid;
  logic [SLOT_W-1:0]        hash_slot;

  logic                     ram_we;
  logic [SLOT_W-1:0]        ram_waddr;
  logic [ENTRY_W-1:0]       ram_wdata;
  logic                     ram_re;
  logic [SLOT_W-1:0]        ram_raddr;
  logic [ENTRY_W-1:0]       ram_rdata;

  logic [TAG_W-1:0]         ent_tag;
  logic [KEY_W-1:0]         ent_key;
  logic [MAX_CODE_BITS-1:0] ent_code;
  logic                     slot_free;
  logic                     hit;
  logic                     miss;
  logic                     insert;

  logic                     push;
  lbe_result_t              push_data;
  lbe_result_t              head_data;
  logic [OUT_CNT_W-1:0]     fifo_count;

  // input side
  assign byte_sat = ({1'b0, data_byte} >= ALPHA_LIM) ? BYTE_TOP : data_byte;
  assign key_in   = KEY_W'({prefix_code, BYTE_W'(0)}) ^ KEY_W'(byte_sat);
  assign accept   = data_valid && !data_stall;
  assign hash_go  = accept && prefix_valid;

  // dictionary slot layout: {epoch tag, key, code}
  assign ent_tag   = ram_rdata[ENTRY_W-1 -: TAG_W];
  assign ent_key   = ram_rdata[MAX_CODE_BITS +: KEY_W];
  assign ent_code  = ram_rdata[MAX_CODE_BITS-1:0];
  assign slot_free = (ent_tag != epoch);
  assign hit       = !slot_free && (ent_key == cur_key);
  assign miss      = !hit && (slot_free || probes == PROBE_ALL);
  assign insert    = miss && slot_free && !next_free_code[MAX_CODE_BITS];
  assign pos_next  = (pos == SLOT_LAST) ? '0 : pos + SLOT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    data_stall = 1'b1;
    ram_we     = 1'b0;
    ram_waddr  = pos;
    ram_wdata  = {epoch, cur_key, next_free_code[MAX_CODE_BITS-1:0]};
    ram_re     = 1'b0;
    ram_raddr  = hash_slot;
    push       = 1'b0;
    push_data  = '{code:       CODE_OUT_W'(prefix_code),
                   code_width: WIDTH_OUT_W'(current_width),
                   final_code: 1'b0};
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        ram_wdata = {EPOCH_CLEAR, (ENTRY_W-TAG_W)'(0)};
        if (clr_idx == SLOT_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // room for both results of the next transaction
        data_stall = (fifo_count > OUT_CNT_W'(OUT_DEPTH - 2));
        if (accept) begin
          if (prefix_valid) begin
            state_next = ST_HASH;
          end else if (end_of_stream) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_HASH: begin
        if (hash_valid) begin
          ram_re     = 1'b1;
          ram_raddr  = hash_slot;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (hit || miss) begin
          push       = miss;
          ram_we     = insert;
          state_next = cur_eos ? ST_FLUSH : ST_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = pos_next;
        end
      end
      ST_FLUSH: begin
        push                 = 1'b1;
        push_data.final_code = 1'b1;
        state_next           = (epoch == EPOCH_LAST) ? ST_CLEAR : ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_code    <= '0;
      prefix_valid   <= 1'b0;
      next_free_code <= NFC_RESET;
      current_width  <= WIDTH_RESET;
      widen_point    <= WP_RESET;
      epoch          <= EPOCH_FIRST;
      clr_idx        <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + SLOT_W'(1);
          epoch   <= EPOCH_FIRST;
        end
        ST_IDLE: begin
          if (accept) begin
            if (!prefix_valid) begin
              prefix_code  <= MAX_CODE_BITS'(byte_sat);
              prefix_valid <= 1'b1;
            end else if (WP_W'(next_free_code) == widen_point &&
                         current_width < WIDTH_MAX) begin
              current_width <= current_width + WIDTH_W'(1);
              widen_point   <= widen_point << 1;
            end
          end
        end
        ST_HASH: begin
        end
        ST_CHECK: begin
          if (hit) begin
            prefix_code <= ent_code;
          end else if (miss) begin
            prefix_code <= MAX_CODE_BITS'(cur_byte);
            if (insert) begin
              next_free_code <= next_free_code + NFC_W'(1);
            end
          end
        end
        ST_FLUSH: begin
          prefix_code    <= '0;
          prefix_valid   <= 1'b0;
          next_free_code <= NFC_RESET;
          current_width  <= WIDTH_RESET;
          widen_point    <= WP_RESET;
          clr_idx        <= '0;
          if (epoch != EPOCH_LAST) begin
            epoch <= epoch + TAG_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // per-transaction payload and probe position
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_byte <= byte_sat;
      cur_eos  <= end_of_stream;
      cur_key  <= key_in;
    end
    if (state == ST_HASH && hash_valid) begin
      pos    <= hash_slot;
      probes <= PROBE_W'(1);
    end else if (state == ST_CHECK && !hit && !miss) begin
      pos    <= pos_next;
      probes <= probes + PROBE_W'(1);
    end
  end

  lbe_hash #(
    .KEY_W (KEY_W),
    .SLOTS (HASH_SLOTS)
  ) u_hash (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hash_go),
    .key       (key_in),
    .out_valid (hash_valid),
    .slot      (hash_slot)
  );

  lbe_dict_ram #(
    .DEPTH  (HASH_SLOTS),
    .DATA_W (ENTRY_W)
  ) u_dict (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lbe_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .out_stall (code_stall),
    .out_valid (code_valid),
    .out_data  (head_data),
    .count     (fifo_count)
  );

  assign code       = head_data.code;
  assign code_width = head_data.code_width;
  assign final_code = head_data.final_code;

endmodule

/* design/lbe_checker.sv */
`timescale 1ns / 1ps
// lbe_checker: port-level checks on lzw_byte_encoder, attached by bind.
// Depends on lbe_pkg and lzw_byte_encoder.
module lbe_checker import lbe_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   data_valid,
  input logic                   data_stall,
  input logic                   end_of_stream,
  input logic                   code_valid,
  input logic                   code_stall,
  input logic [CODE_OUT_W-1:0]  code,
  input logic [WIDTH_OUT_W-1:0] code_width,
  input logic                   final_code
);

  // reset starts the clearing pass: nothing taken, nothing offered
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> data_stall && !code_valid)
    else $error("input open or result offered right after reset");

  // a stream's last byte always leads to hashing or a flush, with input stalled
  a_eos_holds_input: assert property (@(posedge clk) disable iff (rst)
    data_valid && !data_stall && end_of_stream |=> data_stall)
    else $error("input not held after end-of-stream transaction");

  a_out_valid_held: assert property (@(posedge clk) disable iff (rst)
    code_valid && code_stall |=> code_valid)
    else $error("code_valid dropped while stalled");

  a_out_payload_held: assert property (@(posedge clk) disable iff (rst)
    code_valid && code_stall |=>
      $stable(code) && $stable(code_width) && $stable(final_code))
    else $error("result payload changed while stalled");

endmodule

bind lzw_byte_encoder lbe_checker u_lbe_checker (
  .clk           (clk),
  .rst           (rst),
  .data_valid    (data_valid),
  .data_stall    (data_stall),
  .end_of_stream (end_of_stream),
  .code_valid    (code_valid),
  .code_stall    (code_stall),
  .code          (code),
  .code_width    (code_width),
  .final_code    (final_code)
);
